// ===== hdl/ffpa_pkg.sv =====
// shared types, constants and helpers for the first-fit page allocator
// no dependencies; used by the range table, the top level and the checker
package ffpa_pkg;

   localparam int MAX_RANGES = 64;
   localparam int PAGE_BITS  = 20;
   localparam int CNT_BITS   = PAGE_BITS + 1;
   localparam int SUM_BITS   = PAGE_BITS + 2;
   localparam int ADDR_W     = $clog2(MAX_RANGES);
   localparam int IDX_W      = $clog2(MAX_RANGES + 1);

   localparam logic [CNT_BITS-1:0] COUNT_MAX = CNT_BITS'(1) << PAGE_BITS;
   localparam logic [IDX_W-1:0]    TABLE_MAX = IDX_W'(MAX_RANGES);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_BADCOUNT = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [PAGE_BITS-1:0] start;
      logic [CNT_BITS-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } wr_port_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_port_type;

   // clamp a wide length to the page space
   function automatic logic [CNT_BITS-1:0] sat_len(input logic [SUM_BITS-1:0] v);
      logic [CNT_BITS-1:0] r;
      if (v > SUM_BITS'(COUNT_MAX)) r = COUNT_MAX;
      else                          r = v[CNT_BITS-1:0];
      return r;
   endfunction

endpackage

// ===== hdl/ffpa_table.sv =====
// free range table: one write port, one read port with registered data
// depends on ffpa_pkg
module ffpa_table
   import ffpa_pkg::*;
(
   input  logic        clock,
   input  wr_port_type wr,
   input  rd_port_type rd,
   output entry_type   rd_data
);

   entry_type mem [MAX_RANGES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

// ===== hdl/first_fit_page_allocator.sv =====
// first-fit page allocator: sorted free range table with merge on free
// bad count, unused op, full add or alloc over the free total go straight to the result;
//   else add runs an insert pass, allocate a compact pass, free a compact then an insert pass
// one item at a time, each pass streams the table through one read and one write port;
//   the next item is taken the cycle after a result is loaded, a held result stalls it at the end
// reset (synchronous, active high) empties the table and clears the free total; contents stay
module first_fit_page_allocator
   import ffpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // base_page[19:0], page_count[40:20], zero fill
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // start_page[19:0], free_cnt[40:20], zero fill
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPACT,  // alloc: first fit and removal; free: merge and squeeze out
      S_INSERT,   // shift entries up one place behind the insertion point
      S_TAIL,     // last write at the old end of the table
      S_DONE      // hand the item to the output register
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [CNT_BITS-1:0] n_ff, n_in;
   logic [PAGE_BITS-1:0] cs_ff, cs_in;     // range being inserted
   logic [CNT_BITS-1:0] cl_ff, cl_in;
   logic [IDX_W-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0] total_ff, total_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    data_idx_ff, data_idx_in;
   logic [IDX_W-1:0]    wr_idx_ff, wr_idx_in;
   logic                hit_ff, hit_in;    // found a fit, merged, or inserted
   entry_type           pend_ff, pend_in;  // entry carried up by the shift
   logic [PAGE_BITS-1:0] start_ff, start_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [1:0]          rsp_st_ff, rsp_st_in;
   logic [PAGE_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [CNT_BITS-1:0] rsp_free_ff, rsp_free_in;

   wr_port_type wr;
   rd_port_type rd;
   entry_type   rd_data;

   logic [PAGE_BITS-1:0] req_base;
   logic [CNT_BITS-1:0]  req_count;
   logic                 req_fire;
   logic                 pass_end;
   logic [SUM_BITS-1:0]  cur_end;   // end of range being inserted
   logic [SUM_BITS-1:0]  ent_end;   // end of table entry
   logic [SUM_BITS-1:0]  merge_sum;
   logic [SUM_BITS-1:0]  cmp_a, cmp_b;
   logic [SUM_BITS-1:0]  total_sum;
   entry_type            new_ent;

   ffpa_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign req_base   = req_tdata[PAGE_BITS-1:0];
   assign req_count  = req_tdata[PAGE_BITS+CNT_BITS-1:PAGE_BITS];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {{(48 - PAGE_BITS - CNT_BITS){1'b0}}, rsp_free_ff, rsp_start_ff};

   assign pass_end  = (rd_idx_ff == count_ff) && !rd_vld_ff;
   assign cur_end   = SUM_BITS'(cs_ff) + SUM_BITS'(cl_ff);
   assign ent_end   = SUM_BITS'(rd_data.start) + SUM_BITS'(rd_data.len);
   assign merge_sum = SUM_BITS'(cl_ff) + SUM_BITS'(rd_data.len);
   assign total_sum = SUM_BITS'(total_ff) + SUM_BITS'(n_ff);
   assign new_ent   = '{start: cs_ff, len: sat_len(SUM_BITS'(cl_ff))};

   // shared insertion compare: add goes after equal starts,
   // free goes before the first entry starting at or past its end
   always_comb begin
      if (op_ff == OP_ADD) begin
         cmp_a = SUM_BITS'(rd_data.start);
         cmp_b = SUM_BITS'(cs_ff);
      end else begin
         cmp_a = SUM_BITS'(rd_data.start) + SUM_BITS'(1);
         cmp_b = cur_end;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      n_in         = n_ff;
      cs_in        = cs_ff;
      cl_in        = cl_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      data_idx_in  = data_idx_ff;
      wr_idx_in    = wr_idx_ff;
      hit_in       = hit_ff;
      pend_in      = pend_ff;
      start_in     = start_ff;
      status_in    = status_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_st_in    = rsp_st_ff;
      rsp_start_in = rsp_start_ff;
      rsp_free_in  = rsp_free_ff;
      wr           = '0;
      rd           = '0;

      // read issue, shared by both streaming passes
      if ((state_ff == S_COMPACT || state_ff == S_INSERT) && rd_idx_ff != count_ff) begin
         rd.en       = 1'b1;
         rd.addr     = rd_idx_ff[ADDR_W-1:0];
         rd_vld_in   = 1'b1;
         data_idx_in = rd_idx_ff;
         rd_idx_in   = rd_idx_ff + IDX_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser;
               n_in      = req_count;
               cs_in     = req_base;
               cl_in     = req_count;
               rd_idx_in = '0;
               wr_idx_in = '0;
               hit_in    = 1'b0;
               start_in  = '0;
               status_in = ST_OK;
               state_in  = S_DONE;
               if (req_tuser != OP_NOP && req_count == '0) begin
                  status_in = ST_BADCOUNT;
               end else begin
                  priority case (req_tuser)
                     OP_ADD: begin
                        if (count_ff >= TABLE_MAX) status_in = ST_FULL;
                        else                       state_in  = S_INSERT;
                     end
                     OP_ALLOC: begin
                        if (req_count > total_ff) status_in = ST_NOFIT;
                        else                      state_in  = S_COMPACT;
                     end
                     OP_FREE: state_in = S_COMPACT;
                     default: ;
                  endcase
               end
            end
         end

         S_COMPACT: begin
            if (rd_vld_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if (!hit_ff && rd_data.len >= n_ff) begin
                     hit_in   = 1'b1;
                     start_in = rd_data.start;
                     if (rd_data.len != n_ff) begin
                        wr.en         = 1'b1;
                        wr.addr       = wr_idx_ff[ADDR_W-1:0];
                        wr.data.start = rd_data.start + n_ff[PAGE_BITS-1:0];
                        wr.data.len   = rd_data.len - n_ff;
                        wr_idx_in     = wr_idx_ff + IDX_W'(1);
                     end
                  end else begin
                     wr.en     = 1'b1;
                     wr.addr   = wr_idx_ff[ADDR_W-1:0];
                     wr.data   = rd_data;
                     wr_idx_in = wr_idx_ff + IDX_W'(1);
                  end
               end else begin
                  // free: merge with a following or a preceding neighbour
                  if (cur_end == SUM_BITS'(rd_data.start)) begin
                     cl_in  = sat_len(merge_sum);
                     hit_in = 1'b1;
                  end else if (ent_end == SUM_BITS'(cs_ff)) begin
                     cl_in  = sat_len(merge_sum);
                     cs_in  = rd_data.start;
                     hit_in = 1'b1;
                  end else begin
                     wr.en     = 1'b1;
                     wr.addr   = wr_idx_ff[ADDR_W-1:0];
                     wr.data   = rd_data;
                     wr_idx_in = wr_idx_ff + IDX_W'(1);
                  end
               end
            end else if (pass_end) begin
               state_in = S_DONE;
               if (op_ff == OP_ALLOC) begin
                  if (hit_ff) begin
                     total_in = total_ff - n_ff;
                     count_in = wr_idx_ff;
                  end else begin
                     status_in = ST_NOFIT;
                     start_in  = '0;
                  end
               end else begin
                  count_in = wr_idx_ff;
                  if (!hit_ff && count_ff >= TABLE_MAX) begin
                     status_in = ST_FULL;
                  end else begin
                     state_in  = S_INSERT;
                     rd_idx_in = '0;
                     hit_in    = 1'b0;
                  end
               end
            end
         end

         S_INSERT: begin
            if (rd_vld_ff) begin
               if (hit_ff) begin
                  wr.en   = 1'b1;
                  wr.addr = data_idx_ff[ADDR_W-1:0];
                  wr.data = pend_ff;
                  pend_in = rd_data;
               end else if (cmp_a > cmp_b) begin
                  wr.en   = 1'b1;
                  wr.addr = data_idx_ff[ADDR_W-1:0];
                  wr.data = new_ent;
                  pend_in = rd_data;
                  hit_in  = 1'b1;
               end
            end else if (pass_end) begin
               state_in = S_TAIL;
            end
         end

         S_TAIL: begin
            wr.en    = 1'b1;
            wr.addr  = count_ff[ADDR_W-1:0];
            wr.data  = hit_ff ? pend_ff : new_ent;
            count_in = count_ff + IDX_W'(1);
            total_in = sat_len(total_sum);
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in   = 1'b1;
               rsp_st_in    = status_ff;
               rsp_start_in = start_ff;
               rsp_free_in  = total_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         total_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      op_ff        <= op_in;
      n_ff         <= n_in;
      cs_ff        <= cs_in;
      cl_ff        <= cl_in;
      rd_idx_ff    <= rd_idx_in;
      data_idx_ff  <= data_idx_in;
      wr_idx_ff    <= wr_idx_in;
      hit_ff       <= hit_in;
      pend_ff      <= pend_in;
      start_ff     <= start_in;
      status_ff    <= status_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_start_ff <= rsp_start_in;
      rsp_free_ff  <= rsp_free_in;
   end

endmodule

// ===== hdl/ffpa_checker.sv =====
// port-level checks for the first-fit page allocator, bound to the top level
// depends on ffpa_pkg
module ffpa_checker
   import ffpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting an item");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[PAGE_BITS-1:0] == '0)
      else $error("start page set on a failed item");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PAGE_BITS+CNT_BITS-1:PAGE_BITS] <= COUNT_MAX)
      else $error("free total beyond page space");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (.*);
